// ===== rtl/rm3014_pkg.sv =====
// ----------------------------------------------------------------------------
// rm3014_pkg
// Types and constant tables for the shortened (30,14) Reed-Muller codec.
// ----------------------------------------------------------------------------
package rm3014_pkg;

   localparam int MSG_BITS  = 14;
   localparam int PAR_BITS  = 16;
   localparam int WORD_BITS = 30;
   localparam int NUM_CHECKS = 4;

   typedef logic [PAR_BITS-1:0]  par_type;
   typedef logic [MSG_BITS-1:0]  msg_type;
   typedef logic [WORD_BITS-1:0] word_type;

   localparam logic FUNC_ENCODE = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   // Row r belongs to message bit (13 - r).
   localparam par_type GEN_ROWS [MSG_BITS] = '{
      16'h9B60, 16'h2DE0, 16'hFC20, 16'hE03C, 16'h983A, 16'h5436, 16'h2C2E,
      16'hFFDF, 16'h8339, 16'h42B5, 16'h21AD, 16'h1273, 16'h096B, 16'h04E7
   };

   // Four parity check masks for each message bit in transmit order.
   localparam par_type VOTE_MASKS [MSG_BITS][NUM_CHECKS] = '{
      '{16'h2E20, 16'hCD80, 16'h78C0, 16'h9B60},
      '{16'h98A0, 16'hCE40, 16'h7B00, 16'h2DE0},
      '{16'h4960, 16'hAAC0, 16'h1F80, 16'hFC20},
      '{16'h039C, 16'hE03C, 16'h557C, 16'hB6DC},
      '{16'h983A, 16'h2D7A, 16'hCEDA, 16'h7B9A},
      '{16'h02D6, 16'h5436, 16'hE176, 16'hB796},
      '{16'h2C2E, 16'h996E, 16'hCF8E, 16'h7ACE},
      '{16'h4A9F, 16'hA93F, 16'h1C7F, 16'hFFDF},
      '{16'h6099, 16'h8339, 16'h3679, 16'hD5D9},
      '{16'hA115, 16'h1455, 16'h42B5, 16'hF7F5},
      '{16'hC20D, 16'h21AD, 16'h94ED, 16'h774D},
      '{16'h4493, 16'h1273, 16'hA733, 16'hF1D3},
      '{16'h096B, 16'hBC2B, 16'hEACB, 16'h5F8B},
      '{16'h5207, 16'h04E7, 16'hB1A7, 16'hE747}
   };

endpackage

// ===== rtl/rm3014_enc.sv =====
// ----------------------------------------------------------------------------
// rm3014_enc
// Systematic encoder: message on top, generator parity below.
// ----------------------------------------------------------------------------
module rm3014_enc (
   input  rm3014_pkg::msg_type  msg,
   output rm3014_pkg::word_type codeword
);
   import rm3014_pkg::*;

   par_type parity;

   always_comb begin
      parity = '0;
      for (int r = 0; r < MSG_BITS; r++) begin
         if (msg[MSG_BITS-1-r]) begin
            parity = parity ^ GEN_ROWS[r];
         end
      end
   end

   assign codeword = {msg, parity};

endmodule

// ===== rtl/rm3014_dec.sv =====
// ----------------------------------------------------------------------------
// rm3014_dec
// Majority-vote decoder: each message bit is set when at least three of its
// five votes are set.
// ----------------------------------------------------------------------------
module rm3014_dec (
   input  rm3014_pkg::word_type received,
   output rm3014_pkg::msg_type  msg
);
   import rm3014_pkg::*;

   par_type              parity;
   logic [NUM_CHECKS:0]  votes [MSG_BITS];
   logic [2:0]           count [MSG_BITS];

   assign parity = received[PAR_BITS-1:0];

   always_comb begin
      for (int r = 0; r < MSG_BITS; r++) begin
         votes[r][NUM_CHECKS] = received[WORD_BITS-1-r];
         for (int c = 0; c < NUM_CHECKS; c++) begin
            votes[r][c] = ^(parity & VOTE_MASKS[r][c]);
         end
         count[r] = '0;
         for (int k = 0; k <= NUM_CHECKS; k++) begin
            count[r] = count[r] + {2'b00, votes[r][k]};
         end
         msg[MSG_BITS-1-r] = (count[r] >= 3'd3);
      end
   end

endmodule

// ===== rtl/rm_30_14_encode_decode.sv =====
// ----------------------------------------------------------------------------
// rm_30_14_encode_decode
// Shortened (30,14) Reed-Muller encoder and majority-vote decoder.
//
//   Channel   Ports                              Handshake
//   request   req_func, req_word_in              start high, busy low
//   response  rsp_word_out                       rsp_strobe, one cycle
//
// A word is taken in every cycle; busy never rises.
// Each request passes through the input register, then through the encoder
// or decoder into the result register.
// Reset clears the valid flags only; nothing else is held between words.
// The receiver cannot stall, so no word ever waits.
// ----------------------------------------------------------------------------
module rm_30_14_encode_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_func,
   input  rm3014_pkg::word_type req_word_in,
   output logic                 rsp_strobe,
   output rm3014_pkg::word_type rsp_word_out
);
   import rm3014_pkg::*;

   logic     req_valid_ff, req_valid_in;
   logic     req_func_ff;
   word_type req_word_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_word_ff, rsp_word_in;
   word_type enc_word;
   msg_type  dec_msg;

   assign busy         = 1'b0;
   assign req_valid_in = start & ~busy;
   assign rsp_valid_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_func_ff <= req_func;
         req_word_ff <= req_word_in;
      end
      if (rsp_valid_in) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   rm3014_enc u_enc (
      .msg      (req_word_ff[MSG_BITS-1:0]),
      .codeword (enc_word)
   );

   rm3014_dec u_dec (
      .received (req_word_ff),
      .msg      (dec_msg)
   );

   assign rsp_word_in = (req_func_ff == FUNC_DECODE) ?
                        {{(WORD_BITS-MSG_BITS){1'b0}}, dec_msg} : enc_word;

   assign rsp_strobe   = rsp_valid_ff;
   assign rsp_word_out = rsp_word_ff;

`ifndef NO_ASSERTIONS
   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy was raised");

   a_strobe_follows_start : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 2))
      else $error("result strobe without a request two cycles earlier");

   a_decode_upper_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_func, 2) == FUNC_DECODE))
         |-> (rsp_word_out[WORD_BITS-1:MSG_BITS] == '0))
      else $error("decoded word has nonzero upper bits");
`endif

endmodule

// ===== tb/tb_rm_30_14_encode_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rm_30_14_encode_decode
// Self-checking bench for the shortened (30,14) Reed-Muller codec. A short
// table of directed words is followed by random traffic. That traffic is
// codewords with up to three bit errors and plain encode words in equal
// share, plus random noise for the decoder. Words go in bursts with random
// gaps. A local encoder and majority-vote decoder predict untyped results,
// and each strobed result is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_rm_30_14_encode_decode;
   import rm3014_pkg::*;

   localparam int RANDOM_WORDS   = 900;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 4;

   localparam par_type PARITY_ROWS [MSG_BITS] = '{
      16'h9B60, 16'h2DE0, 16'hFC20, 16'hE03C, 16'h983A, 16'h5436, 16'h2C2E,
      16'hFFDF, 16'h8339, 16'h42B5, 16'h21AD, 16'h1273, 16'h096B, 16'h04E7
   };

   localparam par_type CHECK_MASKS [MSG_BITS][NUM_CHECKS] = '{
      '{16'h2E20, 16'hCD80, 16'h78C0, 16'h9B60},
      '{16'h98A0, 16'hCE40, 16'h7B00, 16'h2DE0},
      '{16'h4960, 16'hAAC0, 16'h1F80, 16'hFC20},
      '{16'h039C, 16'hE03C, 16'h557C, 16'hB6DC},
      '{16'h983A, 16'h2D7A, 16'hCEDA, 16'h7B9A},
      '{16'h02D6, 16'h5436, 16'hE176, 16'hB796},
      '{16'h2C2E, 16'h996E, 16'hCF8E, 16'h7ACE},
      '{16'h4A9F, 16'hA93F, 16'h1C7F, 16'hFFDF},
      '{16'h6099, 16'h8339, 16'h3679, 16'hD5D9},
      '{16'hA115, 16'h1455, 16'h42B5, 16'hF7F5},
      '{16'hC20D, 16'h21AD, 16'h94ED, 16'h774D},
      '{16'h4493, 16'h1273, 16'hA733, 16'hF1D3},
      '{16'h096B, 16'hBC2B, 16'hEACB, 16'h5F8B},
      '{16'h5207, 16'h04E7, 16'hB1A7, 16'hE747}
   };

   typedef struct {
      logic     func;
      word_type word;
      bit       typed;
      word_type want;
   } directed_row_type;

   // Rows marked as typed carry their result; the others use the predictor.
   localparam int NUM_DIRECTED = 18;
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{FUNC_ENCODE, 30'h0000_0000, 1'b1, 30'h0000_0000},
      '{FUNC_ENCODE, 30'h3FFF_C000, 1'b1, 30'h0000_0000},
      '{FUNC_ENCODE, 30'h0000_2000, 1'b1, 30'h2000_9B60},
      '{FUNC_ENCODE, 30'h0000_0001, 1'b1, 30'h0001_04E7},
      '{FUNC_ENCODE, 30'h0000_3FFF, 1'b0, 30'h0000_0000},
      '{FUNC_ENCODE, 30'h3FFF_FFFF, 1'b0, 30'h0000_0000},
      '{FUNC_ENCODE, 30'h2AAA_AAAA, 1'b0, 30'h0000_0000},
      '{FUNC_DECODE, 30'h0000_0000, 1'b1, 30'h0000_0000},
      '{FUNC_DECODE, 30'h3FFF_0000, 1'b1, 30'h0000_0000},
      '{FUNC_DECODE, 30'h2000_9B60, 1'b1, 30'h0000_2000},
      '{FUNC_DECODE, 30'h0001_04E7, 1'b1, 30'h0000_0001},
      '{FUNC_DECODE, 30'h3FFF_FFFF, 1'b0, 30'h0000_0000},
      '{FUNC_DECODE, 30'h0000_FFFF, 1'b0, 30'h0000_0000},
      '{FUNC_DECODE, 30'h2000_9B61, 1'b0, 30'h0000_0000},
      '{FUNC_DECODE, 30'h0000_9B60, 1'b0, 30'h0000_0000},
      '{FUNC_DECODE, 30'h2001_9F87, 1'b0, 30'h0000_0000},
      '{FUNC_DECODE, 30'h2AAA_AAAA, 1'b0, 30'h0000_0000},
      '{FUNC_DECODE, 30'h1555_5555, 1'b0, 30'h0000_0000}
   };

   logic     clock       = 1'b0;
   logic     reset       = 1'b1;
   logic     start       = 1'b0;
   logic     req_func    = FUNC_ENCODE;
   word_type req_word_in = '0;
   logic     busy;
   logic     rsp_strobe;
   word_type rsp_word_out;

   bit       req_typed = 1'b0;
   word_type req_want  = '0;

   word_type pending_words [$];
   int       mismatches  = 0;
   int       idle_cycles = 0;

   rm_30_14_encode_decode DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_word_in  (req_word_in),
      .rsp_strobe   (rsp_strobe),
      .rsp_word_out (rsp_word_out)
   );

   always #2 clock = ~clock;

   function automatic word_type codeword_for(input word_type msg);
      word_type cw;
      cw = {msg[MSG_BITS-1:0], {PAR_BITS{1'b0}}};
      for (int r = 0; r < MSG_BITS; r++) begin
         if (msg[MSG_BITS-1-r]) begin
            cw[PAR_BITS-1:0] = cw[PAR_BITS-1:0] ^ PARITY_ROWS[r];
         end
      end
      return cw;
   endfunction

   function automatic word_type message_for(input word_type rx);
      par_type  par;
      word_type msg;
      int       votes;
      par = rx[PAR_BITS-1:0];
      msg = '0;
      for (int r = 0; r < MSG_BITS; r++) begin
         votes = rx[WORD_BITS-1-r];
         for (int c = 0; c < NUM_CHECKS; c++) begin
            votes += ^(par & CHECK_MASKS[r][c]);
         end
         msg[MSG_BITS-1-r] = (votes >= 3);
      end
      return msg;
   endfunction

   task automatic send_word(input logic func, input word_type word, input bit typed,
                            input word_type want);
      req_func    <= func;
      req_word_in <= word;
      req_typed   <= typed;
      req_want    <= want;
      start       <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   always @(posedge clock) begin
      word_type want;
      word_type next_want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_words.size() == 0) begin
            $display("%0t: result %h arrived with no word pending", $time, rsp_word_out);
            mismatches++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_strobe !== 1'b1 || rsp_word_out !== want) begin
               $display("%0t: word_out expected %h actual %h (strobe %b)",
                        $time, want, rsp_word_out, rsp_strobe);
               mismatches++;
            end
         end
      end
      if (!reset && start && busy === 1'b0) begin
         if (req_typed) begin
            next_want = req_want;
         end else if (req_func == FUNC_DECODE) begin
            next_want = message_for(req_word_in);
         end else begin
            next_want = codeword_for(req_word_in);
         end
         pending_words = {pending_words, next_want};
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL rm_30_14_encode_decode");
         $finish;
      end
   end

   initial begin
      int       burst_left;
      int       gap;
      int       kind;
      int       flips;
      word_type word;
      logic     func;

      burst_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_word(directed_rows[i].func, directed_rows[i].word, directed_rows[i].typed,
                   directed_rows[i].want);
      end

      // The sender holds off here until the codec pipeline is empty.
      start <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 2) begin
            start <= 1'b0;
            do @(posedge clock); while (pending_words.size() != 0);
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left = (burst_left > 0) ? burst_left - 1 : 0;

         kind = $urandom_range(0, 9);
         word = word_type'($urandom());
         if (kind < 4) begin
            func = FUNC_ENCODE;
         end else if (kind < 8) begin
            func  = FUNC_DECODE;
            word  = codeword_for(word);
            flips = $urandom_range(0, 3);
            for (int k = 0; k < flips; k++) begin
               word[$urandom_range(0, WORD_BITS - 1)] ^= 1'b1;
            end
         end else begin
            func = FUNC_DECODE;
         end
         send_word(func, word, 1'b0, '0);
      end

      start <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("PASS rm_30_14_encode_decode");
      end else begin
         $display("FAIL rm_30_14_encode_decode");
      end
      $finish;
   end

endmodule
